@@ design/ilid_pkg.sv @@
// Package for the indexed list block: sizes, operation codes and the
// payload and cell control structs. No dependencies.

package ilid_pkg;

  localparam int CAPACITY   = 64;
  localparam int ELEM_WIDTH = 32;
  localparam int KIND_W     = 3;
  localparam int POS_W      = 7;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int CMP_W      = (POS_W > CNT_W) ? POS_W : CNT_W;

  localparam logic [KIND_W-1:0] K_APPEND   = 3'd0;
  localparam logic [KIND_W-1:0] K_INSERT   = 3'd1;
  localparam logic [KIND_W-1:0] K_READ     = 3'd2;
  localparam logic [KIND_W-1:0] K_EXTRACT  = 3'd3;
  localparam logic [KIND_W-1:0] K_POPFRONT = 3'd4;
  localparam logic [KIND_W-1:0] K_POPBACK  = 3'd5;
  localparam logic [KIND_W-1:0] K_CLEAR    = 3'd6;

  typedef struct packed {
    logic [KIND_W-1:0]     kind;
    logic [POS_W-1:0]      position;
    logic [ELEM_WIDTH-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic                  ok;
    logic [ELEM_WIDTH-1:0] element_out;
    logic [CNT_W-1:0]      count;
    logic                  is_empty;
  } out_item_t;

  // Broadcast to every cell in the chain each cycle.
  typedef struct packed {
    logic                  ins;
    logic                  del;
    logic [CMP_W-1:0]      pos;
    logic [CMP_W-1:0]      rd_pos;
    logic [ELEM_WIDTH-1:0] val;
  } cell_ctl_t;

endpackage

@@ design/ilid_cell.sv @@
// One list slot: holds one element and moves it to or from its neighbors.
// Depends on ilid_pkg.

module ilid_cell import ilid_pkg::*; (
  input  logic                  clk,
  input  cell_ctl_t             ctl,
  input  logic [CMP_W-1:0]      idx,
  input  logic [ELEM_WIDTH-1:0] from_lo,
  input  logic [ELEM_WIDTH-1:0] from_hi,
  output logic [ELEM_WIDTH-1:0] data,
  output logic [ELEM_WIDTH-1:0] rd_data
);

  // An insert moves every slot above the position up by one place, and a
  // removal pulls every slot from the position onward down by one place.
  always_ff @(posedge clk) begin
    if (ctl.ins && (idx > ctl.pos)) begin
      data <= from_lo;
    end else if (ctl.ins && (idx == ctl.pos)) begin
      data <= ctl.val;
    end else if (ctl.del && (idx >= ctl.pos)) begin
      data <= from_hi;
    end
  end

  assign rd_data = (idx == ctl.rd_pos) ? data : '0;

endmodule

@@ design/ilid_chain.sv @@
// Row of list cells linked to their neighbors, plus the read-out that
// merges the one selected cell's word. Depends on ilid_pkg and ilid_cell.

module ilid_chain import ilid_pkg::*; (
  input  logic                  clk,
  input  cell_ctl_t             ctl,
  output logic [ELEM_WIDTH-1:0] rd_data
);

  logic [ELEM_WIDTH-1:0] data    [CAPACITY];
  logic [ELEM_WIDTH-1:0] gated   [CAPACITY];
  logic [CAPACITY-1:0]   column  [ELEM_WIDTH];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ELEM_WIDTH-1:0] lo;
    logic [ELEM_WIDTH-1:0] hi;

    // The bottom cell never takes from below, the top cell never from above.
    if (i == 0) begin : g_bottom
      assign lo = ctl.val;
    end else begin : g_lo
      assign lo = data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_top
      assign hi = data[i];
    end else begin : g_hi
      assign hi = data[i+1];
    end

    ilid_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .idx     (CMP_W'(i)),
      .from_lo (lo),
      .from_hi (hi),
      .data    (data[i]),
      .rd_data (gated[i])
    );
  end

  // Only the addressed cell drives a nonzero word, so an OR per bit selects it.
  always_comb begin
    for (int b = 0; b < ELEM_WIDTH; b++) begin
      for (int i = 0; i < CAPACITY; i++) begin
        column[b][i] = gated[i][b];
      end
    end
    for (int b = 0; b < ELEM_WIDTH; b++) begin
      rd_data[b] = |column[b];
    end
  end

endmodule

@@ design/indexed_list_insert_delete.sv @@
// Indexed list top level: operation decode, element count and result register.
// Depends on ilid_pkg and ilid_chain.
//
// Usage: each transfer on the input channel carries one operation (append,
// insert, read, extract, pop front, pop back or clear) with a position and a
// value. Every operation gives exactly one result transfer with a success
// flag, the element read or removed (zero otherwise), the count afterwards
// and an empty flag.
// The result is valid in the cycle after the input transfer. Throughput is
// one operation per cycle while the result is not stalled; all slot moves of
// an insert or a removal happen together across the row of cells, and the
// read comes from the selected cell in the same cycle.
// The result sits in one output register. While it is stalled the input
// is stalled too; as soon as the result is taken a new input can enter in
// the same cycle.
// Reset empties the list and drops any pending result. Slot contents are
// not cleared, since only slots below the count are ever read.

module indexed_list_insert_delete import ilid_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic [CNT_W-1:0]      fill;
  logic [CNT_W-1:0]      fill_next;
  logic                  in_acc;
  logic                  ok_c;
  logic                  take_elem;
  logic [ELEM_WIDTH-1:0] rd_data;
  logic [CMP_W-1:0]      fill_x;
  logic [CMP_W-1:0]      pos_x;
  logic                  full;
  logic                  empty;
  cell_ctl_t             ctl;
  logic                  do_ins;
  logic                  do_del;

  assign in_stall = out_valid && out_stall;
  assign in_acc   = in_valid && !in_stall;

  assign fill_x = CMP_W'(fill);
  assign pos_x  = CMP_W'(in_item.position);
  assign full   = (fill == CNT_W'(CAPACITY));
  assign empty  = (fill == '0);

  always_comb begin
    ok_c       = 1'b0;
    take_elem  = 1'b0;
    do_ins     = 1'b0;
    do_del     = 1'b0;
    fill_next  = fill;
    ctl.pos    = pos_x;
    ctl.rd_pos = pos_x;
    ctl.val    = in_item.value;
    case (in_item.kind)
      K_APPEND: begin
        ok_c    = !full;
        do_ins  = ok_c;
        ctl.pos = fill_x;
      end
      K_INSERT: begin
        ok_c   = !full && (pos_x <= fill_x);
        do_ins = ok_c;
      end
      K_READ: begin
        ok_c      = pos_x < fill_x;
        take_elem = ok_c;
      end
      K_EXTRACT: begin
        ok_c      = pos_x < fill_x;
        take_elem = ok_c;
        do_del    = ok_c;
      end
      K_POPFRONT: begin
        ok_c       = !empty;
        take_elem  = ok_c;
        do_del     = ok_c;
        ctl.pos    = '0;
        ctl.rd_pos = '0;
      end
      K_POPBACK: begin
        ok_c       = !empty;
        take_elem  = ok_c;
        ctl.rd_pos = fill_x - CMP_W'(1);
      end
      K_CLEAR: begin
        ok_c = 1'b1;
      end
      default: begin
        ok_c = 1'b0;
      end
    endcase
    if (do_ins) begin
      fill_next = fill + CNT_W'(1);
    end else if (ok_c && (do_del || (in_item.kind == K_POPBACK))) begin
      fill_next = fill - CNT_W'(1);
    end else if (in_item.kind == K_CLEAR) begin
      fill_next = '0;
    end
    ctl.ins = in_acc && do_ins;
    ctl.del = in_acc && do_del;
  end

  ilid_chain u_chain (
    .clk     (clk),
    .ctl     (ctl),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_acc) begin
        fill      <= fill_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_item.ok          <= ok_c;
      out_item.element_out <= take_elem ? rd_data : '0;
      out_item.count       <= fill_next;
      out_item.is_empty    <= (fill_next == '0);
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(CAPACITY))
    else $error("element count above capacity");

  a_refused_keeps_fill: assert property (@(posedge clk) disable iff (rst)
    in_acc && !ok_c |=> $stable(fill))
    else $error("refused operation changed the element count");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> out_valid && (out_item.count == fill))
    else $error("result missing or count out of step after a transfer");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.is_empty == (out_item.count == '0)))
    else $error("empty flag disagrees with count");

  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.ok |-> (out_item.element_out == '0))
    else $error("refused operation returned an element");

endmodule
